// ===== design/rcst_pkg.sv =====
// Package with types, constants and helpers for the request coalescing slot table.
package rcst_pkg;

    localparam int SHARDS_DEF = 16;
    localparam int SLOTS_DEF  = 8;

    localparam logic [31:0] WAIT_WINDOW_RST     = 32'd1000;
    localparam logic [15:0] MAX_WAITERS_RST     = 16'd64;
    localparam logic [23:0] MAX_BODY_LENGTH_RST = 24'd65536;

    typedef enum logic [2:0] {
        MODE_REGISTER       = 3'd0,
        MODE_COMPLETE_RESP  = 3'd1,
        MODE_COMPLETE_STATE = 3'd2,
        MODE_COMPLETE_GEN   = 3'd3,
        MODE_REMOVE_WAITER  = 3'd4,
        MODE_QUERY          = 3'd5
    } mode_t;

    localparam logic [2:0] ST_INFLIGHT      = 3'd0;
    localparam logic [2:0] ST_STORED        = 3'd1;
    localparam logic [2:0] ST_L1            = 3'd2;
    localparam logic [2:0] ST_L2            = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE     = 3'd4;
    localparam logic [2:0] ST_NOT_CACHEABLE = 3'd5;
    localparam logic [2:0] ST_FAILED        = 3'd6;

    localparam logic [1:0] ROLE_REJECT   = 2'd0;
    localparam logic [1:0] ROLE_LEADER   = 2'd1;
    localparam logic [1:0] ROLE_FOLLOWER = 2'd2;

    localparam logic [3:0] WS_MISSING   = 4'd0;
    localparam logic [3:0] WS_EXPIRED   = 4'd1;
    localparam logic [3:0] WS_SHARED    = 4'd2;
    localparam logic [3:0] WS_STORED_NS = 4'd3;
    localparam logic [3:0] WS_L1        = 4'd4;
    localparam logic [3:0] WS_L2        = 4'd5;
    localparam logic [3:0] WS_TOO_LARGE = 4'd6;
    localparam logic [3:0] WS_NOT_CACHE = 4'd7;
    localparam logic [3:0] WS_FAILED    = 4'd8;
    localparam logic [3:0] WS_PENDING   = 4'd9;

    localparam logic [1:0] CFG_WAIT_WINDOW = 2'd0;
    localparam logic [1:0] CFG_MAX_WAITERS = 2'd1;
    localparam logic [1:0] CFG_MAX_BODY    = 2'd2;

    typedef struct packed {
        logic        active;
        logic [63:0] key;
        logic [2:0]  state;
        logic        snap;
        logic [47:0] created;
        logic [47:0] completed;
        logic [15:0] waiters;
        logic [31:0] gen;
    } slot_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] key_tag;
        logic [47:0] now_time;
        logic [2:0]  completion_state;
        logic [31:0] match_gen;
        logic [23:0] body_length;
    } req_t;

    typedef struct packed {
        logic [1:0]  role;
        logic [31:0] generation;
        logic        done_res;
        logic [3:0]  wait_status;
    } rsp_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_WRITE
    } phase_t;

    function automatic logic window_passed(input logic [47:0] now,
                                           input logic [47:0] t,
                                           input logic [31:0] win);
        logic [48:0] sum;
        sum = {1'b0, t} + {17'd0, win};
        return {1'b0, now} >= sum;
    endfunction

endpackage

// ===== design/rcst_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface rcst_req_if;
    logic          valid;
    logic          ready;
    rcst_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rcst_rsp_if;
    logic          valid;
    logic          ready;
    rcst_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/request_coalescing_slot_table_top.sv =====
// Top level of the request coalescing slot table.
// Each request reads its shard row (all slots of one shard side by side) from a synchronous
// memory, compares and updates it, and writes it back: the request register loads on accept,
// the row is read in the READ phase and written in the WRITE phase, held while a full output
// register is not drained. A request is taken only when idle, initialized, and the output
// register is empty or its response leaves in the same cycle. The slot generations live in
// the row memory and are not cleared by reset, so after reset an initialization pass writes
// a zero row to every shard before the first request is taken.
module request_coalescing_slot_table_top #(
    parameter int SHARDS          = rcst_pkg::SHARDS_DEF,
    parameter int SLOTS_PER_SHARD = rcst_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rcst_req_if.sink    req,
    rcst_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int SW = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int JW = (SLOTS_PER_SHARD > 1) ? $clog2(SLOTS_PER_SHARD) : 1;

    typedef rcst_pkg::slot_t row_t [SLOTS_PER_SHARD];

    rcst_pkg::slot_t mem [SHARDS][SLOTS_PER_SHARD];

    logic [31:0] wait_window_reg;
    logic [15:0] max_waiters_reg;
    logic [23:0] max_body_reg;

    rcst_pkg::phase_t phase_reg, phase_next;
    logic           init_reg;
    logic [SW:0]    init_cnt_reg;
    rcst_pkg::req_t r_reg;
    logic [SW-1:0]  shard_reg;
    row_t           row_rd;
    row_t           row_wr;
    rcst_pkg::rsp_t res;
    rcst_pkg::rsp_t out_reg;
    logic           out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_window_reg <= rcst_pkg::WAIT_WINDOW_RST;
            max_waiters_reg <= rcst_pkg::MAX_WAITERS_RST;
            max_body_reg    <= rcst_pkg::MAX_BODY_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcst_pkg::CFG_WAIT_WINDOW: wait_window_reg <= cfg_data;
                rcst_pkg::CFG_MAX_WAITERS: max_waiters_reg <= cfg_data[15:0];
                rcst_pkg::CFG_MAX_BODY:    max_body_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0] req_shard;
    generate
        if (SHARDS > 1)
        begin : g_sh
            always_comb req_shard = SW'(req.payload.key_tag % 64'(SHARDS));
        end
        else
        begin : g_sh1
            always_comb req_shard = '0;
        end
    endgenerate

    logic can_accept;
    assign can_accept = !init_reg && (phase_reg == rcst_pkg::PH_IDLE) &&
                        (!out_valid_reg || rsp.ready);
    assign req.ready = can_accept;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            rcst_pkg::PH_IDLE:  if (req.valid && can_accept) phase_next = rcst_pkg::PH_READ;
            rcst_pkg::PH_READ:  phase_next = rcst_pkg::PH_WRITE;
            rcst_pkg::PH_WRITE:
            begin
                if (!out_valid_reg || rsp.ready)
                    phase_next = rcst_pkg::PH_IDLE;
            end
            default: phase_next = rcst_pkg::PH_IDLE;
        endcase
    end

    logic do_write;
    assign do_write = (phase_reg == rcst_pkg::PH_WRITE) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rcst_pkg::PH_IDLE;
            init_reg      <= 1'b1;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (init_reg)
            begin
                init_cnt_reg <= init_cnt_reg + (SW+1)'(1);
                if (init_cnt_reg == (SW+1)'(SHARDS - 1))
                    init_reg <= 1'b0;
            end
            if (do_write)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && can_accept)
        begin
            r_reg     <= req.payload;
            shard_reg <= req_shard;
        end
        if (do_write)
            out_reg <= res;
    end

    always_ff @(posedge clk)
    begin
        if (init_reg)
        begin
            for (int j = 0; j < SLOTS_PER_SHARD; j++)
                mem[init_cnt_reg[SW-1:0]][j] <= '0;
        end
        else if (do_write)
        begin
            for (int j = 0; j < SLOTS_PER_SHARD; j++)
                mem[shard_reg][j] <= row_wr[j];
        end
        if (phase_reg == rcst_pkg::PH_READ)
        begin
            for (int j = 0; j < SLOTS_PER_SHARD; j++)
                row_rd[j] <= mem[shard_reg][j];
        end
    end

    always_comb
    begin
        logic            found;
        logic [JW-1:0]   fi;
        logic            placed;
        logic            lead;
        logic [2:0]      cst;
        logic            snap;
        rcst_pkg::slot_t s;
        logic [47:0]     now;
        found  = 1'b0;
        fi     = '0;
        placed = 1'b0;
        lead   = 1'b0;
        snap   = 1'b0;
        now    = r_reg.now_time;
        row_wr = row_rd;
        res    = '0;
        cst    = (r_reg.completion_state == 3'd7) ? rcst_pkg::ST_FAILED
                                                  : r_reg.completion_state;
        for (int j = SLOTS_PER_SHARD - 1; j >= 0; j--)
        begin
            if (row_rd[j].active && row_rd[j].key == r_reg.key_tag)
            begin
                found = 1'b1;
                fi    = JW'(j);
            end
        end
        s = row_rd[fi];
        case (r_reg.mode)
            rcst_pkg::MODE_REGISTER:
            begin
                if (found)
                begin
                    if (s.state == rcst_pkg::ST_NOT_CACHEABLE || s.state == rcst_pkg::ST_FAILED)
                        lead = 1'b1;
                    else if (s.state == rcst_pkg::ST_STORED || s.state == rcst_pkg::ST_L1)
                        lead = rcst_pkg::window_passed(now, s.completed, wait_window_reg);
                    else
                        lead = rcst_pkg::window_passed(now, s.created, wait_window_reg);
                    if (lead)
                    begin
                        row_wr[fi].state   = rcst_pkg::ST_INFLIGHT;
                        row_wr[fi].snap    = 1'b0;
                        row_wr[fi].created = now;
                        row_wr[fi].waiters = '0;
                        row_wr[fi].gen     = s.gen + 32'd1;
                        res.role           = rcst_pkg::ROLE_LEADER;
                        res.generation     = s.gen + 32'd1;
                    end
                    else if (s.waiters < max_waiters_reg)
                    begin
                        row_wr[fi].waiters = s.waiters + 16'd1;
                        res.role           = rcst_pkg::ROLE_FOLLOWER;
                        res.generation     = s.gen;
                    end
                end
                else
                begin
                    for (int j = 0; j < SLOTS_PER_SHARD; j++)
                    begin
                        if (!placed)
                        begin
                            if (!row_rd[j].active ||
                                (row_rd[j].state != rcst_pkg::ST_INFLIGHT &&
                                 row_rd[j].waiters == 16'd0 &&
                                 rcst_pkg::window_passed(now, row_rd[j].completed,
                                                         wait_window_reg)))
                            begin
                                placed              = 1'b1;
                                row_wr[j].active    = 1'b1;
                                row_wr[j].key       = r_reg.key_tag;
                                row_wr[j].state     = rcst_pkg::ST_INFLIGHT;
                                row_wr[j].snap      = 1'b0;
                                row_wr[j].created   = now;
                                row_wr[j].completed = '0;
                                row_wr[j].waiters   = '0;
                                row_wr[j].gen       = row_rd[j].gen + 32'd1;
                                res.role            = rcst_pkg::ROLE_LEADER;
                                res.generation      = row_rd[j].gen + 32'd1;
                            end
                        end
                    end
                end
            end
            rcst_pkg::MODE_COMPLETE_RESP, rcst_pkg::MODE_COMPLETE_STATE,
            rcst_pkg::MODE_COMPLETE_GEN:
            begin
                if (r_reg.mode == rcst_pkg::MODE_COMPLETE_RESP)
                begin
                    if (r_reg.body_length > max_body_reg)
                        cst = rcst_pkg::ST_NOT_CACHEABLE;
                    else
                    begin
                        cst  = rcst_pkg::ST_STORED;
                        snap = 1'b1;
                    end
                end
                if (found && !(r_reg.mode == rcst_pkg::MODE_COMPLETE_GEN &&
                               r_reg.match_gen != 32'd0 &&
                               s.gen != r_reg.match_gen))
                begin
                    row_wr[fi].state     = cst;
                    row_wr[fi].completed = now;
                    if (snap)
                        row_wr[fi].snap = 1'b1;
                    res.done_res = 1'b1;
                end
            end
            rcst_pkg::MODE_REMOVE_WAITER:
            begin
                if (found && s.waiters != 16'd0)
                    row_wr[fi].waiters = s.waiters - 16'd1;
            end
            rcst_pkg::MODE_QUERY:
            begin
                if (!found)
                    res.wait_status = rcst_pkg::WS_MISSING;
                else if (r_reg.match_gen != 32'd0 &&
                         s.gen != r_reg.match_gen)
                    res.wait_status = rcst_pkg::WS_EXPIRED;
                else
                begin
                    case (s.state)
                        rcst_pkg::ST_STORED:
                            res.wait_status = s.snap ? rcst_pkg::WS_SHARED
                                                     : rcst_pkg::WS_STORED_NS;
                        rcst_pkg::ST_L1:            res.wait_status = rcst_pkg::WS_L1;
                        rcst_pkg::ST_L2:            res.wait_status = rcst_pkg::WS_L2;
                        rcst_pkg::ST_TOO_LARGE:     res.wait_status = rcst_pkg::WS_TOO_LARGE;
                        rcst_pkg::ST_NOT_CACHEABLE: res.wait_status = rcst_pkg::WS_NOT_CACHE;
                        rcst_pkg::ST_FAILED:        res.wait_status = rcst_pkg::WS_FAILED;
                        default:                    res.wait_status = rcst_pkg::WS_PENDING;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !req.ready)
        else $error("request accepted during initialization");
    a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> phase_reg == rcst_pkg::PH_READ)
        else $error("accepted request did not start a row read");
    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rcst_pkg::PH_READ |=> phase_reg == rcst_pkg::PH_WRITE)
        else $error("row read not followed by write phase");
    a_out_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> out_valid_reg)
        else $error("row write without a response");
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the request coalescing slot table with its own slot predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int NSLOTS = rcst_pkg::SHARDS_DEF * rcst_pkg::SLOTS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [2:0] ST_SEVEN = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    rcst_req_if req_ch ();
    rcst_rsp_if rsp_ch ();

    request_coalescing_slot_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Slot table mirror and configuration copy.
    logic        tbl_active [NSLOTS];
    logic [63:0] tbl_key [NSLOTS];
    logic [2:0]  tbl_state [NSLOTS];
    logic        tbl_snap [NSLOTS];
    logic [47:0] tbl_created [NSLOTS];
    logic [47:0] tbl_completed [NSLOTS];
    logic [15:0] tbl_waiters [NSLOTS];
    logic [31:0] tbl_gen [NSLOTS];
    logic [31:0] grace_ms;
    logic [15:0] waiter_cap;
    logic [23:0] body_cap;

    rcst_pkg::rsp_t expected_q[$];
    logic [63:0] key_pool [32];
    logic [47:0] clock_ms;
    int          mismatches;
    int          requests_sent;
    int          responses_seen;
    int          idle_cycles;
    int          gap_next;
    bit          no_idle;
    bit          req_held;

    always #5 clk = ~clk;

    function automatic bit elapsed(input logic [47:0] now, input logic [47:0] t);
        return {1'b0, now} >= ({1'b0, t} + {17'd0, grace_ms});
    endfunction

    function automatic int locate(input logic [63:0] k);
        int base;
        base = int'(k[3:0]) * rcst_pkg::SLOTS_DEF;
        for (int j = 0; j < rcst_pkg::SLOTS_DEF; j++)
        begin
            if (tbl_active[base + j] && tbl_key[base + j] == k)
            begin
                return base + j;
            end
        end
        return -1;
    endfunction

    function automatic logic [31:0] claim_slot(input int s, input logic [47:0] now);
        tbl_state[s] = rcst_pkg::ST_INFLIGHT;
        tbl_snap[s] = 1'b0;
        tbl_created[s] = now;
        tbl_waiters[s] = '0;
        tbl_active[s] = 1'b1;
        tbl_gen[s] = tbl_gen[s] + 32'd1;
        return tbl_gen[s];
    endfunction

    function automatic rcst_pkg::rsp_t join_or_lead(input rcst_pkg::req_t r);
        rcst_pkg::rsp_t res;
        int   f;
        int   base;
        int   s;
        bit   lead;
        res = '0;
        f = locate(r.key_tag);
        if (f >= 0)
        begin
            if (tbl_state[f] == rcst_pkg::ST_NOT_CACHEABLE ||
                tbl_state[f] == rcst_pkg::ST_FAILED)
                lead = 1'b1;
            else if (tbl_state[f] == rcst_pkg::ST_STORED || tbl_state[f] == rcst_pkg::ST_L1)
                lead = elapsed(r.now_time, tbl_completed[f]);
            else
                lead = elapsed(r.now_time, tbl_created[f]);
            if (lead)
            begin
                res.generation = claim_slot(f, r.now_time);
                res.role = rcst_pkg::ROLE_LEADER;
            end
            else if (tbl_waiters[f] < waiter_cap)
            begin
                tbl_waiters[f] = tbl_waiters[f] + 16'd1;
                res.role = rcst_pkg::ROLE_FOLLOWER;
                res.generation = tbl_gen[f];
            end
            return res;
        end
        base = int'(r.key_tag[3:0]) * rcst_pkg::SLOTS_DEF;
        for (int j = 0; j < rcst_pkg::SLOTS_DEF; j++)
        begin
            s = base + j;
            if (tbl_active[s] && tbl_state[s] != rcst_pkg::ST_INFLIGHT &&
                tbl_waiters[s] == 0 && elapsed(r.now_time, tbl_completed[s]))
            begin
                tbl_key[s] = '0;
                tbl_created[s] = '0;
                tbl_completed[s] = '0;
                tbl_waiters[s] = '0;
                tbl_active[s] = 1'b0;
                tbl_state[s] = rcst_pkg::ST_INFLIGHT;
                tbl_snap[s] = 1'b0;
            end
            if (!tbl_active[s])
            begin
                tbl_key[s] = r.key_tag;
                tbl_completed[s] = '0;
                res.generation = claim_slot(s, r.now_time);
                res.role = rcst_pkg::ROLE_LEADER;
                return res;
            end
        end
        return res;
    endfunction

    function automatic rcst_pkg::rsp_t predict_response(input rcst_pkg::req_t r);
        rcst_pkg::rsp_t res;
        int         f;
        logic [2:0] cst;
        bit         snap;
        res = '0;
        if (r.mode == rcst_pkg::MODE_REGISTER)
            return join_or_lead(r);
        if (r.mode == MODE_SPARE_A || r.mode == MODE_SPARE_B)
            return res;
        f = locate(r.key_tag);
        cst = (r.completion_state == ST_SEVEN) ? rcst_pkg::ST_FAILED : r.completion_state;
        snap = 1'b0;
        case (r.mode)
            rcst_pkg::MODE_COMPLETE_RESP, rcst_pkg::MODE_COMPLETE_STATE,
            rcst_pkg::MODE_COMPLETE_GEN:
            begin
                if (r.mode == rcst_pkg::MODE_COMPLETE_RESP)
                begin
                    if (r.body_length > body_cap)
                        cst = rcst_pkg::ST_NOT_CACHEABLE;
                    else
                    begin
                        cst = rcst_pkg::ST_STORED;
                        snap = 1'b1;
                    end
                end
                if (f < 0)
                    return res;
                if (r.mode == rcst_pkg::MODE_COMPLETE_GEN && r.match_gen != 0 &&
                    tbl_gen[f] != r.match_gen)
                    return res;
                tbl_state[f] = cst;
                tbl_completed[f] = r.now_time;
                if (snap)
                    tbl_snap[f] = 1'b1;
                res.done_res = 1'b1;
            end
            rcst_pkg::MODE_REMOVE_WAITER:
            begin
                if (f >= 0 && tbl_waiters[f] > 0)
                    tbl_waiters[f] = tbl_waiters[f] - 16'd1;
            end
            default:
            begin
                if (f < 0)
                    res.wait_status = rcst_pkg::WS_MISSING;
                else if (r.match_gen != 0 && tbl_gen[f] != r.match_gen)
                    res.wait_status = rcst_pkg::WS_EXPIRED;
                else
                begin
                    case (tbl_state[f])
                        rcst_pkg::ST_STORED:
                            res.wait_status = tbl_snap[f] ? rcst_pkg::WS_SHARED
                                                          : rcst_pkg::WS_STORED_NS;
                        rcst_pkg::ST_L1:            res.wait_status = rcst_pkg::WS_L1;
                        rcst_pkg::ST_L2:            res.wait_status = rcst_pkg::WS_L2;
                        rcst_pkg::ST_TOO_LARGE:     res.wait_status = rcst_pkg::WS_TOO_LARGE;
                        rcst_pkg::ST_NOT_CACHEABLE: res.wait_status = rcst_pkg::WS_NOT_CACHE;
                        rcst_pkg::ST_FAILED:        res.wait_status = rcst_pkg::WS_FAILED;
                        default:                    res.wait_status = rcst_pkg::WS_PENDING;
                    endcase
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [31:0] current_gen(input logic [63:0] k);
        int f;
        f = locate(k);
        return (f >= 0) ? tbl_gen[f] : 32'd0;
    endfunction

    function automatic rcst_pkg::req_t make_req(input logic [2:0] mode, input logic [63:0] k,
                                                input logic [47:0] now, input logic [2:0] cst,
                                                input logic [31:0] expg,
                                                input logic [23:0] blen);
        rcst_pkg::req_t r;
        r.mode = mode;
        r.key_tag = k;
        r.now_time = now;
        r.completion_state = cst;
        r.match_gen = expg;
        r.body_length = blen;
        return r;
    endfunction

    function automatic int pick_gap();
        int g;
        g = 0;
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 38)
                g++;
        end
        return g;
    endfunction

    task automatic send_request(input rcst_pkg::req_t r);
        repeat (gap_next) @(posedge clk);
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        req_held = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        expected_q.push_back(predict_response(r));
        requests_sent++;
        gap_next = pick_gap();
        if (gap_next > 0)
        begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
    endtask

    task automatic drain_responses();
        if (req_held)
        begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            rcst_pkg::CFG_WAIT_WINDOW: grace_ms = data;
            rcst_pkg::CFG_MAX_WAITERS: waiter_cap = data[15:0];
            default:                   body_cap = data[23:0];
        endcase
    endtask

    task automatic set_limits(input logic [31:0] win, input logic [15:0] waiters,
                              input logic [23:0] body);
        drain_responses();
        write_cfg(rcst_pkg::CFG_WAIT_WINDOW, win);
        write_cfg(rcst_pkg::CFG_MAX_WAITERS, {16'd0, waiters});
        write_cfg(rcst_pkg::CFG_MAX_BODY, {8'd0, body});
        cfg_we <= 1'b0;
    endtask

    function automatic rcst_pkg::req_t random_req();
        rcst_pkg::req_t r;
        int          pick;
        logic [63:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            clock_ms = clock_ms + 48'($urandom_range(0, 300));
        else if (pick < 95)
            clock_ms = clock_ms + 48'($urandom_range(500, 3000));
        else
            clock_ms = 48'({$urandom, $urandom} >> 16);
        if ($urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, 31)];
        else
            k = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.mode = rcst_pkg::MODE_REGISTER;
        else if (pick < 47)
            r.mode = rcst_pkg::MODE_COMPLETE_RESP;
        else if (pick < 57)
            r.mode = rcst_pkg::MODE_COMPLETE_STATE;
        else if (pick < 67)
            r.mode = rcst_pkg::MODE_COMPLETE_GEN;
        else if (pick < 77)
            r.mode = rcst_pkg::MODE_REMOVE_WAITER;
        else if (pick < 96)
            r.mode = rcst_pkg::MODE_QUERY;
        else
            r.mode = (pick[0]) ? MODE_SPARE_A : MODE_SPARE_B;
        r.key_tag = k;
        r.now_time = clock_ms;
        r.completion_state = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.match_gen = '0;
        else if (pick < 80)
            r.match_gen = current_gen(k);
        else
            r.match_gen = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.body_length = 24'(body_cap + 24'($urandom_range(0, 2)) - 24'd1);
        else
            r.body_length = 24'($urandom);
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_req());
    endtask

    task automatic test_directed_cases();
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] kc;
        ka = 64'h1234_5678_9ABC_DEF5;
        kb = 64'h0000_0000_0000_0005;
        kc = 64'hFFFF_0000_FFFF_0005;
        send_request(make_req(rcst_pkg::MODE_REGISTER, ka, 48'd100, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REGISTER, ka, 48'd200, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REMOVE_WAITER, ka, 48'd210,
                              rcst_pkg::ST_INFLIGHT, 32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_QUERY, ka, 48'd220, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_QUERY, ka, 48'd230, rcst_pkg::ST_INFLIGHT,
                              32'd99, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_RESP, ka, 48'd300,
                              rcst_pkg::ST_INFLIGHT, 32'd0, rcst_pkg::MAX_BODY_LENGTH_RST));
        send_request(make_req(rcst_pkg::MODE_QUERY, ka, 48'd310, rcst_pkg::ST_INFLIGHT,
                              32'd1, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_RESP, kb, 48'd320,
                              rcst_pkg::ST_INFLIGHT, 32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REGISTER, kb, 48'd330, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_RESP, kb, 48'd340,
                              rcst_pkg::ST_INFLIGHT, 32'd0,
                              rcst_pkg::MAX_BODY_LENGTH_RST + 24'd1));
        send_request(make_req(rcst_pkg::MODE_QUERY, kb, 48'd350, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REGISTER, kb, 48'd360, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_GEN, kb, 48'd370, rcst_pkg::ST_L2,
                              32'd77, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_GEN, kb, 48'd380, ST_SEVEN,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_QUERY, kb, 48'd390, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_STATE, ka, 48'd400,
                              rcst_pkg::ST_TOO_LARGE, 32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_QUERY, ka, 48'd410, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REGISTER, ka, 48'd5000, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REGISTER, kc, 48'd5010, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_COMPLETE_STATE, kc, 48'd5020,
                              rcst_pkg::ST_STORED, 32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_QUERY, kc, 48'd5030, rcst_pkg::ST_INFLIGHT,
                              32'd0, 24'd0));
        send_request(make_req(MODE_SPARE_A, ka, 48'd5040, rcst_pkg::ST_L1, 32'd0, 24'd0));
        send_request(make_req(MODE_SPARE_B, kb, 48'd5050, rcst_pkg::ST_L1, 32'd0, 24'd0));
        send_request(make_req(rcst_pkg::MODE_REGISTER, '1, '1, ST_SEVEN, '1, '1));
        send_request(make_req(rcst_pkg::MODE_QUERY, '1, '1, ST_SEVEN, '1, '1));
    endtask

    task automatic test_default_limits();
        run_random(100);
        drain_responses();
        run_random(100);
    endtask

    task automatic test_tight_limits();
        set_limits(32'd0, 16'd0, 24'd0);
        run_random(50);
        set_limits(32'd400, 16'd1, 24'd1000);
        run_random(50);
    endtask

    task automatic test_wide_limits();
        set_limits(32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
        run_random(100);
    endtask

    task automatic test_back_to_back();
        set_limits(32'd300, 16'd2, 24'd4096);
        no_idle = 1'b1;
        gap_next = 0;
        run_random(60);
        no_idle = 1'b0;
        run_random(70);
    endtask

    task automatic report(input string what, input logic [31:0] expv, input logic [31:0] gotv);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, expv, gotv);
    endtask

    always @(posedge clk)
    begin
        rcst_pkg::rsp_t want;
        rcst_pkg::rsp_t got;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.payload;
                responses_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("response with no request outstanding");
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.role !== want.role)
                        report("role", want.role, got.role);
                    if (got.generation !== want.generation)
                        report("generation", want.generation, got.generation);
                    if (got.done_res !== want.done_res)
                        report("done_res", want.done_res, got.done_res);
                    if (got.wait_status !== want.wait_status)
                        report("wait_status", want.wait_status, got.wait_status);
                end
            end
            rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 38);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("[request_coalescing_slot_table_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] rnd_hi;
        logic [31:0] rnd_lo;
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        requests_sent = 0;
        responses_seen = 0;
        idle_cycles = 0;
        gap_next = 0;
        no_idle = 1'b0;
        req_held = 1'b0;
        clock_ms = 48'd6000;
        grace_ms = rcst_pkg::WAIT_WINDOW_RST;
        waiter_cap = rcst_pkg::MAX_WAITERS_RST;
        body_cap = rcst_pkg::MAX_BODY_LENGTH_RST;
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_active[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_state[i] = rcst_pkg::ST_INFLIGHT;
            tbl_snap[i] = 1'b0;
            tbl_created[i] = '0;
            tbl_completed[i] = '0;
            tbl_waiters[i] = '0;
            tbl_gen[i] = '0;
        end
        for (int i = 0; i < 32; i++)
        begin
            rnd_hi = $urandom;
            rnd_lo = $urandom;
            key_pool[i] = {rnd_hi, rnd_lo[31:4], 4'(2 + (i % 3) * 5)};
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_default_limits();
        test_tight_limits();
        test_wide_limits();
        test_back_to_back();
        drain_responses();
        $display("Sent %0d requests and checked %0d responses over five limit settings,",
                 requests_sent, responses_seen);
        $display("including zero and full-scale windows, waiter caps and body caps.");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[request_coalescing_slot_table_top] OK");
        else
            $display("[request_coalescing_slot_table_top] ERROR");
        $finish;
    end

endmodule
